// ===== src/olist_pkg.sv =====
// shared types and constants for the ordered list block
`default_nettype none
package olist_pkg;

  localparam int LIST_DEPTH = 512;
  localparam int ADDR_W     = $clog2(LIST_DEPTH);
  localparam int POS_W      = 10;
  localparam int ID_W       = 64;
  localparam int REC_W      = 3 * ID_W;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_LOCATE = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_READ  = 6'b000100,
    S_DRAIN = 6'b001000,
    S_PUT   = 6'b010000,
    S_DONE  = 6'b100000
  } olist_state_e;

  typedef struct packed {
    logic load;
    logic check;
    logic rd;
    logic proc;
    logic put;
    logic emit;
  } olist_ctrl_t;

  typedef struct packed {
    logic go_read;
    logic ins_ok;
    logic last_read;
    logic hit;
    logic out_free;
  } olist_stat_t;

endpackage
`default_nettype wire

// ===== src/ordered_list_insert_delete_locate.sv =====
// steps: accept, check, walk the entries, drain the last read, write the entry for an insert, then emit
// insert at p walks count-p+1 entries, delete at p walks count-p+1, locate walks to first match
// the walk reads the list memory one entry a cycle
// one item at a time; the next item is taken once the result sits in the output register
// reset clears the entry count and control state; list memory is not cleared
`default_nettype none
module ordered_list_insert_delete_locate
  import olist_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // position, first_id, second_id, payload, zero pad
  input  wire logic [207:0] s_axis_tdata,
  // command, match_on_second
  input  wire logic [2:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // found_position, out_first_id, out_second_id, out_payload, list_count, zero pad
  output logic [215:0]      m_axis_tdata,
  // status
  output logic [1:0]        m_axis_tuser
);

  olist_ctrl_t      ctrl;
  olist_stat_t      stat;
  logic [POS_W-1:0] found_position, list_count;
  logic [ID_W-1:0]  out_first_id, out_second_id, out_payload;

  olist_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .stat_i    (stat),
    .ctrl_o    (ctrl)
  );

  olist_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .ctrl_i              (ctrl),
    .stat_o              (stat),
    .in_command_i        (s_axis_tuser[1:0]),
    .in_position_i       (s_axis_tdata[9:0]),
    .in_match_on_second_i(s_axis_tuser[2]),
    .in_first_id_i       (s_axis_tdata[73:10]),
    .in_second_id_i      (s_axis_tdata[137:74]),
    .in_payload_i        (s_axis_tdata[201:138]),
    .out_valid_o         (m_axis_tvalid),
    .out_ready_i         (m_axis_tready),
    .out_status_o        (m_axis_tuser),
    .out_found_position_o(found_position),
    .out_first_id_o      (out_first_id),
    .out_second_id_o     (out_second_id),
    .out_payload_o       (out_payload),
    .out_list_count_o    (list_count)
  );

  assign m_axis_tdata = {4'b0, list_count, out_payload, out_second_id, out_first_id,
                         found_position};

endmodule
`default_nettype wire

// ===== src/olist_ram.sv =====
// generic simple dual-port ram with registered read
`default_nettype none
module olist_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== src/olist_ctrl.sv =====
// sequencing state machine for the ordered list
`default_nettype none
module olist_ctrl
  import olist_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire olist_stat_t stat_i,
  output olist_ctrl_t      ctrl_o
);

  olist_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          state_d     = S_CHECK;
        end
      end
      S_CHECK: begin
        ctrl_o.check = 1'b1;
        if (stat_i.go_read) begin
          state_d = S_READ;
        end else if (stat_i.ins_ok) begin
          state_d = S_PUT;
        end else begin
          state_d = S_DONE;
        end
      end
      S_READ: begin
        ctrl_o.rd   = 1'b1;
        ctrl_o.proc = 1'b1;
        if (stat_i.hit) begin
          state_d = S_DONE;
        end else if (stat_i.last_read) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        ctrl_o.proc = 1'b1;
        if (stat_i.hit) begin
          state_d = S_DONE;
        end else if (stat_i.ins_ok) begin
          state_d = S_PUT;
        end else begin
          state_d = S_DONE;
        end
      end
      S_PUT: begin
        ctrl_o.put = 1'b1;
        state_d    = S_DONE;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          ctrl_o.emit = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// ===== src/olist_dp.sv =====
// datapath: item registers, list memory, pointers and result register
`default_nettype none
module olist_dp
  import olist_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire olist_ctrl_t       ctrl_i,
  output olist_stat_t            stat_o,
  input  wire logic [1:0]        in_command_i,
  input  wire logic [POS_W-1:0]  in_position_i,
  input  wire logic              in_match_on_second_i,
  input  wire logic [ID_W-1:0]   in_first_id_i,
  input  wire logic [ID_W-1:0]   in_second_id_i,
  input  wire logic [ID_W-1:0]   in_payload_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [1:0]             out_status_o,
  output logic [POS_W-1:0]       out_found_position_o,
  output logic [ID_W-1:0]        out_first_id_o,
  output logic [ID_W-1:0]        out_second_id_o,
  output logic [ID_W-1:0]        out_payload_o,
  output logic [POS_W-1:0]       out_list_count_o
);

  logic [1:0]        cmd_q;
  logic [POS_W-1:0]  pos_q;
  logic              sel_q;
  logic [ID_W-1:0]   a_q, b_q, p_q;
  logic [POS_W-1:0]  count_q, count_d;
  logic [ADDR_W-1:0] ptr_q, rptr_q;
  logic              rvld_q;
  logic [POS_W-1:0]  found_q;
  logic [ID_W-1:0]   rem_a_q, rem_b_q, rem_p_q;
  logic              out_valid_q;

  logic              ins_range, ins_full, del_range;
  logic              is_ins, is_del, is_loc, ins_ok, del_ok;
  logic [1:0]        status;
  logic [ADDR_W-1:0] pos_m1, cnt_m1;
  logic [REC_W-1:0]  rdata, wdata;
  logic [ADDR_W-1:0] waddr;
  logic              we;
  logic [ID_W-1:0]   key, cand;
  logic              match, at_pos;

  assign is_ins = (cmd_q == CMD_INSERT);
  assign is_del = (cmd_q == CMD_DELETE);
  assign is_loc = (cmd_q == CMD_LOCATE);

  assign ins_range = (pos_q == '0) ||
                     ({1'b0, pos_q} > ({1'b0, count_q} + (POS_W+1)'(1)));
  assign ins_full  = (count_q == POS_W'(LIST_DEPTH));
  assign del_range = (pos_q == '0) || (pos_q > count_q);
  assign ins_ok    = is_ins && !ins_range && !ins_full;
  assign del_ok    = is_del && !del_range;

  always_comb begin
    status = ST_OK;
    if (is_ins && ins_range) begin
      status = ST_RANGE;
    end else if (is_ins && ins_full) begin
      status = ST_FULL;
    end else if (is_del && del_range) begin
      status = ST_RANGE;
    end
  end

  assign pos_m1 = ADDR_W'(pos_q - POS_W'(1));
  assign cnt_m1 = ADDR_W'(count_q - POS_W'(1));

  assign key    = sel_q ? b_q : a_q;
  assign cand   = sel_q ? rdata[2*ID_W-1:ID_W] : rdata[ID_W-1:0];
  assign match  = (cand == key);
  assign at_pos = (rptr_q == pos_m1);

  assign stat_o.go_read   = (ins_ok && (pos_q <= count_q)) || del_ok ||
                            (is_loc && (count_q != '0));
  assign stat_o.ins_ok    = ins_ok;
  assign stat_o.last_read = is_ins ? (ptr_q == pos_m1) : (ptr_q == cnt_m1);
  assign stat_o.hit       = ctrl_i.proc && rvld_q && is_loc && match;
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = rdata;
    if (ctrl_i.put) begin
      we    = 1'b1;
      waddr = pos_m1;
      wdata = {p_q, b_q, a_q};
    end else if (ctrl_i.proc && rvld_q) begin
      if (is_ins) begin
        we    = 1'b1;
        waddr = rptr_q + ADDR_W'(1);
      end else if (is_del && !at_pos) begin
        we    = 1'b1;
        waddr = rptr_q - ADDR_W'(1);
      end
    end
  end

  olist_ram #(
    .WIDTH(REC_W),
    .DEPTH(LIST_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (ctrl_i.rd),
    .raddr_i(ptr_q),
    .rdata_o(rdata)
  );

  always_comb begin
    count_d = count_q;
    if (ins_ok) begin
      count_d = count_q + POS_W'(1);
    end else if (del_ok) begin
      count_d = count_q - POS_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q   <= in_command_i;
      pos_q   <= in_position_i;
      sel_q   <= in_match_on_second_i;
      a_q     <= in_first_id_i;
      b_q     <= in_second_id_i;
      p_q     <= in_payload_i;
      found_q <= '0;
      rem_a_q <= '0;
      rem_b_q <= '0;
      rem_p_q <= '0;
    end else begin
      if (stat_o.hit) begin
        found_q <= POS_W'(rptr_q) + POS_W'(1);
      end
      if (ctrl_i.proc && rvld_q && del_ok && at_pos) begin
        rem_a_q <= rdata[ID_W-1:0];
        rem_b_q <= rdata[2*ID_W-1:ID_W];
        rem_p_q <= rdata[REC_W-1:2*ID_W];
      end
    end
    if (ctrl_i.check) begin
      if (is_ins) begin
        ptr_q <= cnt_m1;
      end else if (is_del) begin
        ptr_q <= pos_m1;
      end else begin
        ptr_q <= '0;
      end
    end else if (ctrl_i.rd) begin
      ptr_q <= is_ins ? ptr_q - ADDR_W'(1) : ptr_q + ADDR_W'(1);
    end
    if (ctrl_i.rd) begin
      rptr_q <= ptr_q;
    end
    if (ctrl_i.emit) begin
      out_status_o         <= status;
      out_found_position_o <= found_q;
      out_first_id_o       <= rem_a_q;
      out_second_id_o      <= rem_b_q;
      out_payload_o        <= rem_p_q;
      out_list_count_o     <= count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rvld_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rvld_q <= ctrl_i.rd;
      if (ctrl_i.emit) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// ===== verif/ordered_list_checker.sv =====
// checker for the ordered list: predicts every result from the accepted items and compares them
`timescale 1ns / 100ps
module ordered_list_checker
  import olist_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_tvalid_i,
  input  wire logic         s_tready_i,
  // position, first_id, second_id, payload, zero pad
  input  wire logic [207:0] s_tdata_i,
  // command, match_on_second
  input  wire logic [2:0]   s_tuser_i,
  input  wire logic         m_tvalid_i,
  input  wire logic         m_tready_i,
  // found_position, out_first_id, out_second_id, out_payload, list_count, zero pad
  input  wire logic [215:0] m_tdata_i,
  // status
  input  wire logic [1:0]   m_tuser_i,
  output int                fail_count_o,
  output int                pending_o,
  output int                list_len_o,
  output int                results_o
);

  localparam int PRINT_LIMIT = 20;

  typedef struct packed {
    logic [1:0]       status;
    logic [POS_W-1:0] found_pos;
    logic [ID_W-1:0]  rem_first;
    logic [ID_W-1:0]  rem_second;
    logic [ID_W-1:0]  rem_payload;
    logic [POS_W-1:0] entries_after;
  } olist_result_t;

  logic [ID_W-1:0] list_first   [LIST_DEPTH];
  logic [ID_W-1:0] list_second  [LIST_DEPTH];
  logic [ID_W-1:0] list_payload [LIST_DEPTH];
  int unsigned     n_entries;
  olist_result_t   expected_q [$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    list_len_o   = 0;
    results_o    = 0;
    n_entries    = 0;
  end

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    fail_count_o++;
    if (fail_count_o <= PRINT_LIMIT) begin
      $display("%0t mismatch on %s: got %h, expected %h", $realtime, field, got, want);
    end
  endtask

  function automatic olist_result_t apply_to_list(input logic [1:0] cmd,
                                                  input logic [POS_W-1:0] pos_field,
                                                  input logic on_second,
                                                  input logic [ID_W-1:0] id_a,
                                                  input logic [ID_W-1:0] id_b,
                                                  input logic [ID_W-1:0] data);
    olist_result_t res;
    int unsigned   pos;
    int unsigned   k;
    logic [ID_W-1:0] key;
    logic [ID_W-1:0] held;
    res = '0;
    res.status = ST_OK;
    pos = pos_field;
    case (cmd)
      CMD_INSERT: begin
        if (pos == 0 || pos > n_entries + 1) begin
          res.status = ST_RANGE;
        end else if (n_entries >= LIST_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          for (k = n_entries; k > pos - 1; k--) begin
            list_first[k]   = list_first[k-1];
            list_second[k]  = list_second[k-1];
            list_payload[k] = list_payload[k-1];
          end
          list_first[pos-1]   = id_a;
          list_second[pos-1]  = id_b;
          list_payload[pos-1] = data;
          n_entries++;
        end
      end
      CMD_DELETE: begin
        if (pos == 0 || pos > n_entries) begin
          res.status = ST_RANGE;
        end else begin
          res.rem_first   = list_first[pos-1];
          res.rem_second  = list_second[pos-1];
          res.rem_payload = list_payload[pos-1];
          for (k = pos; k < n_entries; k++) begin
            list_first[k-1]   = list_first[k];
            list_second[k-1]  = list_second[k];
            list_payload[k-1] = list_payload[k];
          end
          n_entries--;
        end
      end
      CMD_LOCATE: begin
        key = on_second ? id_b : id_a;
        for (k = 0; k < n_entries; k++) begin
          held = on_second ? list_second[k] : list_first[k];
          if (held == key) begin
            res.found_pos = POS_W'(k + 1);
            break;
          end
        end
      end
      default: begin
      end
    endcase
    res.entries_after = POS_W'(n_entries);
    return res;
  endfunction

  always @(posedge clk_i) begin
    olist_result_t want;
    olist_result_t got;
    if (!rst_ni) begin
      n_entries = 0;
      expected_q.delete();
    end else begin
      if (s_tvalid_i && s_tready_i) begin
        expected_q.push_back(apply_to_list(s_tuser_i[1:0], s_tdata_i[9:0], s_tuser_i[2],
                                           s_tdata_i[73:10], s_tdata_i[137:74],
                                           s_tdata_i[201:138]));
      end
      if (m_tvalid_i && m_tready_i) begin
        results_o++;
        got.status        = m_tuser_i;
        got.found_pos     = m_tdata_i[9:0];
        got.rem_first     = m_tdata_i[73:10];
        got.rem_second    = m_tdata_i[137:74];
        got.rem_payload   = m_tdata_i[201:138];
        got.entries_after = m_tdata_i[211:202];
        if (expected_q.size() == 0) begin
          report_mismatch("result with no item pending", got.rem_first, '0);
        end else begin
          want = expected_q.pop_front();
          if (got.status != want.status)
            report_mismatch("status", got.status, want.status);
          if (got.found_pos != want.found_pos)
            report_mismatch("found_position", got.found_pos, want.found_pos);
          if (got.rem_first != want.rem_first)
            report_mismatch("out_first_id", got.rem_first, want.rem_first);
          if (got.rem_second != want.rem_second)
            report_mismatch("out_second_id", got.rem_second, want.rem_second);
          if (got.rem_payload != want.rem_payload)
            report_mismatch("out_payload", got.rem_payload, want.rem_payload);
          if (got.entries_after != want.entries_after)
            report_mismatch("list_count", got.entries_after, want.entries_after);
        end
      end
    end
    pending_o  = expected_q.size();
    list_len_o = n_entries;
  end

endmodule

// ===== verif/ordered_list_insert_delete_locate_tb.sv =====
// testbench top for the ordered list: clock, reset, stimulus, watchdog and verdict
`timescale 1ns / 100ps
module ordered_list_insert_delete_locate_tb;
  import olist_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 8 * (LIST_DEPTH + 4) + 200;
  localparam int POOL_SIZE   = 8;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [207:0] s_axis_tdata = '0;
  logic [2:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [215:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  int fail_count;
  int pending;
  int list_len;
  int results_seen;

  logic quiet = 1'b0;
  int   stall_cycles = 0;
  int   n_by_cmd [4];
  int   n_full_tries = 0;
  int   longest = 0;
  logic [ID_W-1:0] id_pool [POOL_SIZE];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  ordered_list_insert_delete_locate u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  ordered_list_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tuser_i    (m_axis_tuser),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .list_len_o   (list_len),
    .results_o    (results_seen)
  );

  always @(negedge clk_i) begin
    m_axis_tready = quiet || ($urandom_range(0, 99) >= 20);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", stall_cycles);
        $display("[ordered_list_insert_delete_locate] ERROR");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  function automatic logic [ID_W-1:0] pick_id();
    if ($urandom_range(0, 1) == 0) begin
      return id_pool[$urandom_range(0, POOL_SIZE - 1)];
    end
    return {$urandom, $urandom};
  endfunction

  task automatic send_item(input logic [1:0] cmd, input int unsigned pos, input logic sel,
                           input logic [ID_W-1:0] id_a, input logic [ID_W-1:0] id_b,
                           input logic [ID_W-1:0] data);
    while (!quiet && $urandom_range(0, 99) < 20) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    n_by_cmd[cmd]++;
    if (cmd == CMD_INSERT && list_len == LIST_DEPTH) n_full_tries++;
    s_axis_tdata  = {6'd0, data, id_b, id_a, POS_W'(pos)};
    s_axis_tuser  = {sel, cmd};
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    if (list_len > longest) longest = list_len;
  endtask

  task automatic wait_for_results();
    while (pending != 0) @(negedge clk_i);
  endtask

  // one random item steering the list length towards target
  task automatic random_step(input int target, input int focus, input int tail_pct);
    int          r;
    int unsigned pos;
    r = $urandom_range(0, 99);
    if (r < (100 - focus) / 3) begin
      send_item(2'($urandom_range(0, 3)), $urandom_range(0, 1023), 1'($urandom),
                {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
    end else if (r < 100 - focus) begin
      send_item(CMD_LOCATE, $urandom_range(0, 1023), 1'($urandom), pick_id(), pick_id(),
                {$urandom, $urandom});
    end else if (list_len < target || list_len == 0) begin
      pos = ($urandom_range(0, 99) < tail_pct) ? list_len + 1 : $urandom_range(1, list_len + 1);
      send_item(CMD_INSERT, pos, 1'($urandom), pick_id(), pick_id(), {$urandom, $urandom});
    end else begin
      pos = ($urandom_range(0, 99) < tail_pct) ? list_len : $urandom_range(1, list_len);
      send_item(CMD_DELETE, pos, 1'($urandom), {$urandom, $urandom}, {$urandom, $urandom},
                {$urandom, $urandom});
    end
  endtask

  initial begin
    int target;
    foreach (n_by_cmd[i]) n_by_cmd[i] = 0;
    id_pool[0] = '0;
    id_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) id_pool[i] = {$urandom, $urandom};

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // empty list and bad positions
    send_item(CMD_LOCATE, 0, 1'b0, '0, '0, '0);
    send_item(CMD_DELETE, 1, 1'b0, '1, '1, '1);
    send_item(CMD_DELETE, 0, 1'b0, '0, '0, '0);
    send_item(CMD_INSERT, 0, 1'b0, '1, '1, '1);
    send_item(CMD_INSERT, 2, 1'b0, '1, '1, '1);
    // front, end and middle inserts, duplicate first id, then locates, an unused command and deletes
    send_item(CMD_INSERT, 1, 1'b1, '1, '1, '1);
    send_item(CMD_INSERT, 1, 1'b0, '0, '0, '0);
    send_item(CMD_INSERT, 3, 1'b0, 64'ha5a5_a5a5_a5a5_a5a5, 64'h5a5a_5a5a_5a5a_5a5a,
              64'h8000_0000_0000_0001);
    send_item(CMD_INSERT, 2, 1'b1, '1, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
    send_item(CMD_LOCATE, 1023, 1'b0, '1, '0, '1);
    send_item(CMD_LOCATE, 5, 1'b1, '1, '0, '0);
    send_item(CMD_LOCATE, 0, 1'b1, '0, 64'h0000_0000_0000_0007, '0);
    send_item(CMD_UNUSED, 1023, 1'b1, '1, '1, '1);
    send_item(CMD_INSERT, 1023, 1'b0, '1, '1, '1);
    send_item(CMD_INSERT, 6, 1'b0, '1, '1, '1);
    send_item(CMD_DELETE, 5, 1'b0, '0, '0, '0);
    send_item(CMD_DELETE, 1023, 1'b0, '0, '0, '0);
    send_item(CMD_DELETE, 2, 1'b0, '0, '0, '0);
    send_item(CMD_DELETE, 3, 1'b1, '1, '1, '1);
    send_item(CMD_DELETE, 1, 1'b0, '0, '0, '0);
    send_item(CMD_DELETE, 1, 1'b0, '0, '0, '0);
    send_item(CMD_LOCATE, 1, 1'b1, '0, '0, '0);
    wait_for_results();

    // short list, random traffic
    target = 8;
    for (int i = 0; i < 110; i++) begin
      if (i % 16 == 0) target = $urandom_range(0, 30);
      quiet = (i >= 30 && i < 80);
      random_step(target, 70, 30);
    end
    quiet = 1'b0;
    wait_for_results();

    // grow to a full list, then try inserts, deletes and locates on it
    while (list_len < LIST_DEPTH) random_step(LIST_DEPTH, 92, 75);
    send_item(CMD_INSERT, LIST_DEPTH + 2, 1'b0, '1, '1, '1);
    send_item(CMD_INSERT, LIST_DEPTH + 1, 1'b0, '1, '1, '1);
    send_item(CMD_INSERT, 1, 1'b1, '0, '0, '0);
    send_item(CMD_DELETE, LIST_DEPTH + 1, 1'b0, '0, '0, '0);
    send_item(CMD_LOCATE, 1, 1'b0, 64'h0bad_0bad_0bad_0bad, '0, '0);
    send_item(CMD_LOCATE, 1, 1'b1, '0, 64'h0bad_0bad_0bad_0bad, '0);
    send_item(CMD_DELETE, LIST_DEPTH, 1'b0, '0, '0, '0);
    for (int i = 0; i < 12; i++) random_step(LIST_DEPTH, 80, 50);
    wait_for_results();

    // drain back to empty
    while (list_len > 0) random_step(0, 92, 75);
    for (int i = 0; i < 10; i++) random_step(2, 60, 50);

    s_axis_tvalid = 1'b0;
    wait_for_results();
    repeat (LIST_DEPTH + 16) @(negedge clk_i);

    $display("items: %0d insert, %0d delete, %0d locate, %0d unused; %0d results checked",
             n_by_cmd[CMD_INSERT], n_by_cmd[CMD_DELETE], n_by_cmd[CMD_LOCATE],
             n_by_cmd[CMD_UNUSED], results_seen);
    $display("list grew to %0d of %0d entries, %0d inserts tried on a full list",
             longest, LIST_DEPTH, n_full_tries);
    if (fail_count == 0) begin
      $display("[ordered_list_insert_delete_locate] OK");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("[ordered_list_insert_delete_locate] ERROR");
    end
    $finish;
  end

endmodule
